### hw/rtl/bfbc_pkg.sv
// shared constants, command codes and control structs for the buddy free block coalescer
// no dependencies; imported by bfbc_ctrl, bfbc_dp, buddy_free_block_coalescer and its testbench
package bfbc_pkg;

  // map geometry
  localparam int ADDR_BITS = 10;
  localparam int MAX_ORDER = 10;
  localparam int TOP_ORDER = (MAX_ORDER < ADDR_BITS) ? MAX_ORDER : ADDR_BITS;

  // port field widths
  localparam int ORDER_W  = 4;
  localparam int ADDR_W   = 10;
  localparam int STATUS_W = 2;

  // free map storage: heap-indexed bits packed into words
  localparam int SLOT_W    = ADDR_BITS + 1;
  localparam int WORD_LOG  = (ADDR_BITS >= 5) ? 5 : ADDR_BITS;
  localparam int WORD_BITS = 1 << WORD_LOG;
  localparam int ROW_BITS  = SLOT_W - WORD_LOG;
  localparam int ROWS      = 1 << ROW_BITS;

  // opcodes
  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_SCAN    = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP_FREE  = 2'd3;

  // datapath command codes
  localparam int DP_OP_W = 4;
  localparam logic [DP_OP_W-1:0] DP_NOP        = 4'd0;
  localparam logic [DP_OP_W-1:0] DP_CLEAR      = 4'd1;
  localparam logic [DP_OP_W-1:0] DP_LOAD       = 4'd2;
  localparam logic [DP_OP_W-1:0] DP_SET_ERR    = 4'd3;
  localparam logic [DP_OP_W-1:0] DP_ORDER_INIT = 4'd4;
  localparam logic [DP_OP_W-1:0] DP_ORDER_UP   = 4'd5;
  localparam logic [DP_OP_W-1:0] DP_READ       = 4'd6;
  localparam logic [DP_OP_W-1:0] DP_MRG_STEP   = 4'd7;
  localparam logic [DP_OP_W-1:0] DP_SCAN_INIT  = 4'd8;
  localparam logic [DP_OP_W-1:0] DP_SCAN_STEP  = 4'd9;
  localparam logic [DP_OP_W-1:0] DP_EMIT       = 4'd10;

  typedef struct packed {
    logic [DP_OP_W-1:0]  op;
    logic [STATUS_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic err_order;
    logic err_align;
    logic is_scan;
    logic scan_empty;
    logic blk_free;
    logic at_top;
    logic buddy_free;
    logic scan_hit;
    logic last_row;
    logic clear_last;
  } dp_stat_t;

endpackage

### hw/rtl/bfbc_dp.sv
// datapath of the coalescer: free map memory, request registers, result registers
// depends on bfbc_pkg; driven by commands from bfbc_ctrl
module bfbc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  bfbc_pkg::dp_cmd_t                cmd,
  output bfbc_pkg::dp_stat_t               stat,
  input  logic                             opcode,
  input  logic [bfbc_pkg::ORDER_W-1:0]     block_order,
  input  logic [bfbc_pkg::ADDR_W-1:0]      block_address,
  output logic                             done,
  output logic [bfbc_pkg::STATUS_W-1:0]    status,
  output logic                             found,
  output logic [bfbc_pkg::ORDER_W-1:0]     result_order,
  output logic [bfbc_pkg::ADDR_W-1:0]      result_address
);
  import bfbc_pkg::*;

  function automatic logic [ADDR_BITS-1:0] low_mask(input logic [ORDER_W-1:0] k);
    low_mask = ~({ADDR_BITS{1'b1}} << k);
  endfunction

  function automatic logic [SLOT_W-1:0] base_of(input logic [ORDER_W-1:0] k);
    base_of = {1'b1, {ADDR_BITS{1'b0}}} >> k;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [ORDER_W-1:0] k,
                                                 input logic [ADDR_BITS-1:0] a);
    slot_of = base_of(k) + {1'b0, a >> k};
  endfunction

  // request registers
  logic                 op_q;
  logic [ORDER_W-1:0]   k_q;
  logic [ADDR_BITS-1:0] a_q;
  logic [ORDER_W-1:0]   ck;
  logic [SLOT_W-1:0]    scan_slot;
  logic [SLOT_W-1:0]    end_slot;
  logic [SLOT_W-1:0]    rd_slot;
  logic [WORD_BITS-1:0] rd_word;
  logic [ROW_BITS-1:0]  clr_row;

  logic [WORD_BITS-1:0] mem [ROWS];

  // combinational helpers
  logic [SLOT_W-1:0]    base;
  logic [SLOT_W-1:0]    idx_sum;
  logic [SLOT_W-1:0]    idx;
  logic [SLOT_W-1:0]    first_slot;
  logic [SLOT_W-1:0]    last_slot;
  logic [SLOT_W-1:0]    cur_slot;
  logic [SLOT_W-1:0]    rd_addr;
  logic [WORD_LOG-1:0]  bit_pos;
  logic [WORD_LOG-1:0]  buddy_pos;
  logic                 at_top;
  logic                 merge;
  logic [WORD_BITS-1:0] mrg_word;
  logic                 wr_en;
  logic [ROW_BITS-1:0]  wr_row;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic                 same_row;
  logic [WORD_LOG-1:0]  lo;
  logic [WORD_LOG-1:0]  hi;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_LOG-1:0]  pos;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    hit_off;
  logic [SLOT_W-1:0]    hit_shift;

  always_comb begin
    base       = base_of(k_q);
    idx_sum    = {1'b0, a_q} + {1'b0, low_mask(k_q)};
    idx        = idx_sum >> k_q;
    first_slot = base + idx;
    last_slot  = (base << 1) - SLOT_W'(1);
    cur_slot   = slot_of(ck, a_q);
    rd_addr    = (op_q == OP_SCAN) ? scan_slot : cur_slot;
    bit_pos    = rd_slot[WORD_LOG-1:0];
    buddy_pos  = bit_pos ^ WORD_LOG'(1);
    at_top     = (ck == ORDER_W'(TOP_ORDER));
    merge      = !at_top && rd_word[buddy_pos];
    if (merge) begin
      mrg_word = rd_word & ~(WORD_BITS'(1) << buddy_pos);
    end else begin
      mrg_word = rd_word | (WORD_BITS'(1) << bit_pos);
    end
    rd_en   = (cmd.op == DP_READ);
    wr_en   = (cmd.op == DP_CLEAR) || (cmd.op == DP_MRG_STEP);
    wr_row  = (cmd.op == DP_CLEAR) ? clr_row : rd_slot[SLOT_W-1:WORD_LOG];
    wr_data = (cmd.op == DP_CLEAR) ? '0 : mrg_word;
  end

  // scan window inside the current word and lowest set bit
  always_comb begin
    same_row = (scan_slot[SLOT_W-1:WORD_LOG] == end_slot[SLOT_W-1:WORD_LOG]);
    lo       = scan_slot[WORD_LOG-1:0];
    hi       = same_row ? end_slot[WORD_LOG-1:0] : {WORD_LOG{1'b1}};
    for (int i = 0; i < WORD_BITS; i++) begin
      masked[i] = rd_word[i] && (WORD_LOG'(i) >= lo) && (WORD_LOG'(i) <= hi);
    end
    hit = |masked;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) pos = WORD_LOG'(i);
    end
    hit_slot  = {scan_slot[SLOT_W-1:WORD_LOG], pos};
    hit_off   = hit_slot - base;
    hit_shift = hit_off << k_q;
  end

  always_comb begin
    stat.err_order  = (k_q > ORDER_W'(TOP_ORDER));
    stat.err_align  = ((a_q & low_mask(k_q)) != '0);
    stat.is_scan    = (op_q == OP_SCAN);
    stat.scan_empty = (idx >= base);
    stat.blk_free   = rd_word[bit_pos];
    stat.at_top     = at_top;
    stat.buddy_free = rd_word[buddy_pos];
    stat.scan_hit   = hit;
    stat.last_row   = same_row;
    stat.clear_last = (clr_row == {ROW_BITS{1'b1}});
  end

  // free map memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr[SLOT_W-1:WORD_LOG]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      clr_row <= '0;
    end else begin
      done <= (cmd.op == DP_EMIT);
      if (cmd.op == DP_CLEAR) begin
        clr_row <= clr_row + ROW_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_q           <= opcode;
        k_q            <= block_order;
        a_q            <= block_address[ADDR_BITS-1:0];
        status         <= ST_OK;
        found          <= 1'b0;
        result_order   <= block_order;
        result_address <= ADDR_W'(block_address[ADDR_BITS-1:0]);
      end
      DP_SET_ERR: status <= cmd.code;
      DP_ORDER_INIT: ck <= k_q;
      DP_ORDER_UP: ck <= ck + ORDER_W'(1);
      DP_READ: rd_slot <= rd_addr;
      DP_MRG_STEP: begin
        if (merge) begin
          ck <= ck + ORDER_W'(1);
        end else begin
          result_order   <= ck;
          result_address <= ADDR_W'(a_q & ~low_mask(ck));
        end
      end
      DP_SCAN_INIT: begin
        scan_slot      <= first_slot;
        end_slot       <= last_slot;
        result_address <= '0;
      end
      DP_SCAN_STEP: begin
        if (hit) begin
          found          <= 1'b1;
          result_address <= ADDR_W'(hit_shift[ADDR_BITS-1:0]);
        end else begin
          scan_slot <= {scan_slot[SLOT_W-1:WORD_LOG] + ROW_BITS'(1), {WORD_LOG{1'b0}}};
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/bfbc_ctrl.sv
// controller state machine of the coalescer
// depends on bfbc_pkg; sequences bfbc_dp through command and status structs
module bfbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bfbc_pkg::dp_stat_t  stat,
  output bfbc_pkg::dp_cmd_t   cmd
);
  import bfbc_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_DUP_RD   = 4'd3;
  localparam logic [3:0] S_DUP_CHK  = 4'd4;
  localparam logic [3:0] S_MRG_RD   = 4'd5;
  localparam logic [3:0] S_MRG_ACT  = 4'd6;
  localparam logic [3:0] S_SCAN_RD  = 4'd7;
  localparam logic [3:0] S_SCAN_CHK = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    cmd.code   = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.err_order) begin
          cmd.op     = DP_SET_ERR;
          cmd.code   = ST_BAD_ORDER;
          state_next = S_EMIT;
        end else if (stat.is_scan) begin
          cmd.op     = DP_SCAN_INIT;
          state_next = stat.scan_empty ? S_EMIT : S_SCAN_RD;
        end else if (stat.err_align) begin
          cmd.op     = DP_SET_ERR;
          cmd.code   = ST_MISALIGN;
          state_next = S_EMIT;
        end else begin
          cmd.op     = DP_ORDER_INIT;
          state_next = S_DUP_RD;
        end
      end
      S_DUP_RD: begin
        cmd.op     = DP_READ;
        state_next = S_DUP_CHK;
      end
      S_DUP_CHK: begin
        if (stat.blk_free) begin
          cmd.op     = DP_SET_ERR;
          cmd.code   = ST_DUP_FREE;
          state_next = S_EMIT;
        end else if (stat.at_top) begin
          cmd.op     = DP_ORDER_INIT;
          state_next = S_MRG_RD;
        end else begin
          cmd.op     = DP_ORDER_UP;
          state_next = S_DUP_RD;
        end
      end
      S_MRG_RD: begin
        cmd.op     = DP_READ;
        state_next = S_MRG_ACT;
      end
      S_MRG_ACT: begin
        cmd.op     = DP_MRG_STEP;
        state_next = (!stat.at_top && stat.buddy_free) ? S_MRG_RD : S_EMIT;
      end
      S_SCAN_RD: begin
        cmd.op     = DP_READ;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.op     = DP_SCAN_STEP;
        state_next = (stat.scan_hit || stat.last_row) ? S_EMIT : S_SCAN_RD;
      end
      S_EMIT: begin
        cmd.op     = DP_EMIT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/buddy_free_block_coalescer.sv
// top level of the buddy free block coalescer: free map with release merging and scan
// depends on bfbc_pkg, bfbc_ctrl and bfbc_dp
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  request   | start, busy          | opcode, block_order, block_address
//  result    | done (one-cycle)     | status, found, result_order, result_address
//
// a request is taken on a clock edge with start high and busy low; one result per request
// release: one map read and one check per level, from the block's order up to the top order,
//   looking for the block or an enclosing block already free; then one read and one merge
//   step per level while the buddy is free, stopping at the top order
// scan: one map read and one check per 32-bit map word walked at that order
// reset clears all 64 map words, one map word per cycle, and busy stays high meanwhile
// done is high for exactly one cycle; the receiver cannot hold it off
module buddy_free_block_coalescer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic [bfbc_pkg::ORDER_W-1:0]     block_order,
  input  logic [bfbc_pkg::ADDR_W-1:0]      block_address,
  output logic                             done,
  output logic [bfbc_pkg::STATUS_W-1:0]    status,
  output logic                             found,
  output logic [bfbc_pkg::ORDER_W-1:0]     result_order,
  output logic [bfbc_pkg::ADDR_W-1:0]      result_address
);
  import bfbc_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: clearing pass, error decode, ancestor check, merge climb, word walk
  bfbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: map memory of 32-bit words, request and result registers
  bfbc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .block_order    (block_order),
    .block_address  (block_address),
    .done           (done),
    .status         (status),
    .found          (found),
    .result_order   (result_order),
    .result_address (result_address)
  );

endmodule

### dv/buddy_free_block_coalescer_tb.sv
// self-checking testbench for buddy_free_block_coalescer: release merging, duplicate and error
// detection, and next-free-block scans against an in-bench free map predictor
// depends on bfbc_pkg and the buddy_free_block_coalescer rtl
module buddy_free_block_coalescer_tb;
  import bfbc_pkg::*;

  // one request as it goes to the block
  typedef struct {
    logic                op;
    logic [ORDER_W-1:0]  order;
    logic [ADDR_W-1:0]   addr;
  } blk_req_t;

  // one result as it comes back
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [ORDER_W-1:0]  order;
    logic [ADDR_W-1:0]   addr;
  } blk_res_t;

  localparam int MAP_SLOTS = 1 << (ADDR_BITS + 1);
  localparam int ADDR_MASK = (1 << ADDR_BITS) - 1;
  // settle time after the last result, above the worst scan latency
  localparam int DRAIN_CYCLES = 120;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                opcode = OP_RELEASE;
  logic [ORDER_W-1:0]  block_order = '0;
  logic [ADDR_W-1:0]   block_address = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [ORDER_W-1:0]  result_order;
  logic [ADDR_W-1:0]   result_address;

  buddy_free_block_coalescer uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .block_order   (block_order),
    .block_address (block_address),
    .done          (done),
    .status        (status),
    .found         (found),
    .result_order  (result_order),
    .result_address(result_address)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // requests not yet taken by the block, and results the free map says must come back
  blk_req_t req_pending[$];
  blk_res_t merge_due[$];

  // shadow free map, heap indexed like the block: slot (k, a) = 2^(ADDR_BITS-k) + a>>k
  bit free_bits [0:MAP_SLOTS-1];

  int errors     = 0;
  int n_results  = 0;
  int n_merged   = 0;
  int n_dup      = 0;
  int n_rejected = 0;
  int n_hits     = 0;
  int n_misses   = 0;

  function automatic int slot_of(input int k, input int a);
    return (1 << (ADDR_BITS - k)) + (a >> k);
  endfunction

  // apply one request to the shadow map and give the result it must produce
  function automatic blk_res_t free_map_step(input blk_req_t r);
    blk_res_t res;
    int k, a, j, ck, ca, idx, cnt;
    bit covered;
    k = int'(r.order);
    a = int'(r.addr) & ADDR_MASK;
    res.status = ST_OK;
    res.found  = 1'b0;
    res.order  = r.order;
    res.addr   = ADDR_W'(a);
    if (k > TOP_ORDER) begin
      // rejected for both opcodes, map untouched
      res.status = ST_BAD_ORDER;
      n_rejected++;
    end else if (r.op == OP_RELEASE) begin
      if ((a & ((1 << k) - 1)) != 0) begin
        res.status = ST_MISALIGN;
        n_rejected++;
      end else begin
        // the block itself or any enclosing block already free means a double release
        covered = 1'b0;
        for (j = k; j <= TOP_ORDER; j++)
          if (free_bits[slot_of(j, a & ~((1 << j) - 1))]) covered = 1'b1;
        if (covered) begin
          res.status = ST_DUP_FREE;
          n_dup++;
        end else begin
          // climb while the buddy is free, stopping at the top order
          ck = k;
          ca = a;
          while (ck < TOP_ORDER && free_bits[slot_of(ck, ca ^ (1 << ck))]) begin
            free_bits[slot_of(ck, ca ^ (1 << ck))] = 1'b0;
            ca = ca & ~(1 << ck);
            ck++;
          end
          free_bits[slot_of(ck, ca)] = 1'b1;
          res.order = ORDER_W'(ck);
          res.addr  = ADDR_W'(ca);
          if (ck > k) n_merged++;
        end
      end
    end else begin
      // scan from the first aligned start at or above the address
      cnt = 1 << (ADDR_BITS - k);
      idx = (a + (1 << k) - 1) >> k;
      res.addr = '0;
      while (idx < cnt && !res.found) begin
        if (free_bits[slot_of(k, idx << k)]) begin
          res.found = 1'b1;
          res.addr  = ADDR_W'(idx << k);
        end else begin
          idx++;
        end
      end
      if (res.found) n_hits++;
      else n_misses++;
    end
    return res;
  endfunction

  task automatic push_req(input logic op, input int k, input int a);
    blk_req_t r;
    r.op    = op;
    r.order = ORDER_W'(k);
    r.addr  = ADDR_W'(a);
    req_pending.push_back(r);
  endtask

  // driver: bursts of back-to-back requests separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic nxt_start;
    blk_req_t taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        // request taken at this edge: predict now, in acceptance order
        taken = req_pending.pop_front();
        merge_due.push_back(free_map_step(taken));
        nxt_start = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // mostly short bursts, sometimes a long stretch with no idling
          if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 120);
          else burst_left = $urandom_range(0, 15);
          if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(10, 40);
          else gap_left = $urandom_range(1, 6);
        end
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pending.size() > 0) begin
          opcode        <= req_pending[0].op;
          block_order   <= req_pending[0].order;
          block_address <= req_pending[0].addr;
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: done is a one-cycle strobe, every strobe must match the oldest prediction
  always @(posedge clk) begin
    blk_res_t got, want;
    string exp_s, act_s;
    if (!rst && done) begin
      got.status = status;
      got.found  = found;
      got.order  = result_order;
      got.addr   = result_address;
      n_results++;
      if (merge_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d found=%0d order=%0d addr=%0d",
                 $time, got.status, got.found, got.order, got.addr);
      end else begin
        want = merge_due.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.order !== want.order || got.addr !== want.addr) begin
          errors++;
          exp_s = $sformatf("status=%0d found=%0d order=%0d addr=%0d",
                            want.status, want.found, want.order, want.addr);
          act_s = $sformatf("status=%0d found=%0d order=%0d addr=%0d",
                            got.status, got.found, got.order, got.addr);
          $display("%0t: result %0d expected %s, actual %s", $time, n_results, exp_s, act_s);
        end
      end
    end
  end

  initial begin
    int w, i, n, sel, k, a;

    // directed: empty map scans, error cases, merges at the top of the space
    push_req(OP_SCAN, 0, 0);            // nothing found on an empty map
    push_req(OP_SCAN, TOP_ORDER, ADDR_MASK);
    push_req(OP_SCAN, 15, ADDR_MASK);    // order too large on a scan
    push_req(OP_RELEASE, 11, 5);         // order too large on a release
    push_req(OP_RELEASE, 15, ADDR_MASK);
    push_req(OP_RELEASE, 1, 1);          // misaligned starts
    push_req(OP_RELEASE, 10, 512);
    push_req(OP_RELEASE, 3, ADDR_MASK);
    push_req(OP_RELEASE, 0, ADDR_MASK);  // highest unit
    push_req(OP_RELEASE, 0, ADDR_MASK - 1);  // its buddy, merges to order 1
    push_req(OP_RELEASE, 0, ADDR_MASK);  // inside a larger free block
    push_req(OP_RELEASE, 1, ADDR_MASK - 1);  // the free block itself again
    push_req(OP_RELEASE, 2, ADDR_MASK - 3);  // contains a smaller free block, still taken
    push_req(OP_SCAN, 1, 0);
    push_req(OP_SCAN, 2, ADDR_MASK - 2);  // misaligned scan rolls past the end
    push_req(OP_SCAN, 2, ADDR_MASK - 3);
    push_req(OP_RELEASE, 0, 0);
    push_req(OP_SCAN, 0, 0);
    push_req(OP_RELEASE, 0, 1);          // merges with unit 0
    push_req(OP_SCAN, 0, 0);             // merged away, not found at order 0
    push_req(OP_SCAN, 1, 1);

    // random: fill the space one 64-unit window at a time so merges keep happening,
    // mixed with scans anywhere, stray releases, and error requests
    for (w = 0; w < 16; w++) begin
      n = $urandom_range(100, 130);
      for (i = 0; i < n; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          // well-formed release inside the current window, small orders favored
          case ($urandom_range(0, 9))
            0, 1, 2, 3: k = 0;
            4, 5:       k = 1;
            6:          k = 2;
            7:          k = 3;
            8:          k = 4;
            default:    k = $urandom_range(5, 6);
          endcase
          a = w * 64 + ($urandom_range(0, 63) & ~((1 << k) - 1));
          push_req(OP_RELEASE, k, a);
        end else if (sel < 75) begin
          push_req(OP_SCAN, $urandom_range(0, TOP_ORDER), $urandom_range(0, ADDR_MASK));
        end else if (sel < 85) begin
          // stray aligned release anywhere in the space
          k = $urandom_range(0, 3);
          push_req(OP_RELEASE, k, $urandom_range(0, ADDR_MASK) & ~((1 << k) - 1));
        end else if (sel < 92) begin
          // misaligned release: force a low bit below the alignment
          k = $urandom_range(1, TOP_ORDER);
          a = $urandom_range(0, ADDR_MASK);
          if ((a & ((1 << k) - 1)) == 0) a = a | (1 << $urandom_range(0, k - 1));
          push_req(OP_RELEASE, k, a);
        end else begin
          push_req(1'($urandom_range(0, 1)), $urandom_range(TOP_ORDER + 1, 15),
                   $urandom_range(0, ADDR_MASK));
        end
      end
    end

    // tail: whole-space block once the map has filled up
    push_req(OP_RELEASE, TOP_ORDER, 0);
    push_req(OP_SCAN, TOP_ORDER, 0);
    push_req(OP_SCAN, TOP_ORDER, 1);
    push_req(OP_SCAN, 0, ADDR_MASK);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (req_pending.size() != 0 || merge_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results: %0d merging releases, %0d double releases, %0d rejected",
             n_results, n_merged, n_dup, n_rejected);
    $display("scans: %0d found a free block, %0d found none; %0d mismatches",
             n_hits, n_misses, errors);
    if (errors == 0 && merge_due.size() == 0) begin
      $display("buddy_free_block_coalescer_tb OK");
    end else begin
      $display("buddy_free_block_coalescer_tb NOT OK");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3500000;
    $display("timeout with %0d requests pending and %0d results due",
             req_pending.size(), merge_due.size());
    $display("buddy_free_block_coalescer_tb NOT OK");
    $finish;
  end

endmodule

### files.f
hw/rtl/bfbc_pkg.sv
hw/rtl/bfbc_dp.sv
hw/rtl/bfbc_ctrl.sv
hw/rtl/buddy_free_block_coalescer.sv
dv/buddy_free_block_coalescer_tb.sv
